FILE: src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and constants for the utf-8 to utf-16 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    // output queue sizing
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

    // most results one byte can cause
    localparam int unsigned MAX_RES  = 2;
    localparam int unsigned RES_CW   = $clog2(MAX_RES + 1);

    // results caused by one accepted byte, in order
    typedef struct packed {
        logic [RES_CW-1:0] count;
        logic [15:0]       unit0;
        logic [15:0]       unit1;
    } u8d_res_t;

    // one queued result
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
    } u8d_entry_t;

endpackage

`default_nettype wire

FILE: src/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// per-byte decode step and sequence state registers
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_decode (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic [7:0]       in_byte,
    output u8d_pkg::u8d_res_t     res
);
    import u8d_pkg::*;

    logic [1:0]  pending_count_reg, pending_count_next;
    logic [15:0] partial_value_reg, partial_value_next;

    logic [15:0] merged;
    logic [1:0]  dec_count;

    // fresh byte handling, also used after an interrupted sequence
    logic        fr_emit;
    logic [15:0] fr_unit;
    logic        fr_open;
    logic [1:0]  fr_pend;
    logic [15:0] fr_value;

    always_comb begin
        fr_emit  = 1'b0;
        fr_unit  = {8'h00, in_byte};
        fr_open  = 1'b0;
        fr_pend  = 2'd0;
        fr_value = partial_value_reg;
        if (in_byte inside {[8'h00:8'h7F]}) begin
            fr_emit = 1'b1;
        end else if (in_byte inside {[8'h80:8'hBF]}) begin
            // lone continuation byte is dropped
        end else if (in_byte inside {[8'hC0:8'hDF]}) begin
            fr_open  = 1'b1;
            fr_pend  = 2'd1;
            fr_value = {5'd0, in_byte[4:0], 6'd0};
        end else if (in_byte inside {[8'hE0:8'hEF]}) begin
            fr_open  = 1'b1;
            fr_pend  = 2'd2;
            fr_value = {in_byte[3:0], 12'd0};
        end else begin
            // four-byte and invalid leads pass through raw
            fr_emit = 1'b1;
        end
    end

    always_comb begin
        merged    = (pending_count_reg >= 2'd2)
                  ? (partial_value_reg | {4'd0, in_byte[5:0], 6'd0})
                  : (partial_value_reg | {10'd0, in_byte[5:0]});
        dec_count = pending_count_reg - 2'd1;

        pending_count_next = pending_count_reg;
        partial_value_next = partial_value_reg;
        res.count = '0;
        res.unit0 = '0;
        res.unit1 = '0;

        if (pending_count_reg != 2'd0) begin
            if (in_byte[7:6] == 2'b10) begin
                partial_value_next = merged;
                pending_count_next = dec_count;
                if (dec_count == 2'd0) begin
                    res.count = RES_CW'(1);
                    res.unit0 = merged;
                end
            end else begin
                // interrupted: flush partial value, then treat byte as new
                res.unit0 = partial_value_reg;
                res.unit1 = fr_unit;
                res.count = fr_emit ? RES_CW'(2) : RES_CW'(1);
                pending_count_next = fr_open ? fr_pend : 2'd0;
                partial_value_next = fr_value;
            end
        end else begin
            res.unit0 = fr_unit;
            res.count = fr_emit ? RES_CW'(1) : RES_CW'(0);
            if (fr_open) begin
                pending_count_next = fr_pend;
                partial_value_next = fr_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_count_reg <= 2'd0;
            partial_value_reg <= 16'd0;
        end else if (in_fire) begin
            pending_count_reg <= pending_count_next;
            partial_value_reg <= partial_value_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/u8d_outq.sv
// ----------------------------------------------------------------------------
// u8d_outq
// small result queue, takes up to two results per cycle, gives one on m_ready
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_outq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire u8d_pkg::u8d_res_t     res,
    output logic                       room,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [15:0]                m_code_unit,
    output logic                       m_last_of_run
);
    import u8d_pkg::*;

    u8d_entry_t        mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0]  count_reg, count_next;
    logic [RES_CW-1:0] n_push;
    logic              pop;
    logic [OQ_AW-1:0]  wr_ptr_p1;
    u8d_entry_t        head;

    assign n_push    = push ? res.count : '0;
    assign pop       = m_valid && m_ready;
    assign wr_ptr_p1 = wr_ptr_reg + OQ_AW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(n_push);
        rd_ptr_next = pop ? (rd_ptr_reg + OQ_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg + OQ_CW'(n_push) - (pop ? OQ_CW'(1) : OQ_CW'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != '0) begin
            mem[wr_ptr_reg] <= '{code_unit: res.unit0, last_of_run: (n_push == RES_CW'(1))};
        end
        if (n_push == RES_CW'(MAX_RES)) begin
            mem[wr_ptr_p1] <= '{code_unit: res.unit1, last_of_run: 1'b1};
        end
    end

    assign head          = mem[rd_ptr_reg];
    assign room          = (count_reg <= OQ_CW'(OQ_DEPTH - MAX_RES));
    assign m_valid       = (count_reg != '0);
    assign m_code_unit   = head.code_unit;
    assign m_last_of_run = head.last_of_run;

endmodule

`default_nettype wire

FILE: src/utf8_to_utf16_decoder.sv
// each result is registered in the result queue and offered on m_ from its head
// throughput: one byte per cycle if s_ready; one code unit per cycle if m_ready
// a byte that flushes an interrupted sequence and also emits gives two code units
// s_ready is low while the four-entry result queue holds more than two results
// reset (aresetn low, synchronous) closes any open sequence and empties the queue
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// streaming utf-8 to utf-16 (bmp) decoder, one byte per request
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    // code unit output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_code_unit,
    output logic             m_last_of_run
);
    import u8d_pkg::*;

    // decode result for the byte at the input
    u8d_res_t dec_res;
    logic     in_fire;
    logic     q_room;

    // accept only when the queue can take the worst case of two results
    assign s_ready = q_room;
    assign in_fire = s_valid && s_ready;

    // sequence state lives here, updated once per accepted byte
    u8d_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_in_byte),
        .res      (dec_res)
    );

    // result queue doubles as the output register and decouples m_ready
    u8d_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (in_fire),
        .res           (dec_res),
        .room          (q_room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire
